// ----- src/gdfs_pkg.sv -----
// Package: shared constants, codes and state type for the graph depth-first walk unit.
`timescale 1ns / 1ps
package gdfs_pkg;

    localparam int NODES_DEF = 64;
    localparam int CNT_W     = 7;
    localparam int ID_W      = 6;
    localparam int ADDR_W    = 3;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

    typedef enum logic [1:0]
    {
        FUNC_ADD_EDGE = 2'd0,
        FUNC_WALK     = 2'd1,
        FUNC_WALK_ALL = 2'd2,
        FUNC_CLEAR    = 2'd3
    } func_t;

    localparam logic REG_NODE_COUNT = 1'b0;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_E_RD,
        ST_E_DEG,
        ST_E_SCAN,
        ST_E_CMP,
        ST_E_WR,
        ST_W_START,
        ST_W_DEG,
        ST_W_STEP,
        ST_W_NBR,
        ST_W_PUSH,
        ST_W_POP,
        ST_A_SCAN,
        ST_FIN
    } state_t;

endpackage

// ----- src/gdfs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/graph_dfs_components_unit.sv -----
// Top level: undirected graph store with depth-first walks over all or one component.
// Add edge: per endpoint, read its degree, scan its stored list for a duplicate, then write; both endpoints in turn.
// Walk: each visited node is emitted, its degree read, then its stored list stepped through by the
//   walk sequencer over the single neighbor RAM read port; a walk over all components also scans
//   ids for unvisited starts. Output stalls hold the walk. Input not ready during a request.
// Reset: async active low; lists empty, node_count 64, output empty. No clearing pass.
`timescale 1ns / 1ps
module graph_dfs_components_unit
    import gdfs_pkg::*;
#(
    parameter int NODES = NODES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // func[1:0], node_a[7:2], node_b[13:8], zero pad
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // visited_node[5:0], zero pad
    output logic              m_axis_tlast,
    output logic              m_axis_tuser,   // component_end
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int NIDX = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SW   = NIDX + CNT_W;
    localparam logic [CNT_W-1:0] NODES_C = CNT_W'(NODES);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] node_count_reg;
    logic             pass_reg, pass_next;
    logic             all_reg, all_next;
    logic [NIDX-1:0]  from_reg, from_next, to_reg, to_next;
    logic [CNT_W-1:0] d_reg, d_next, i_reg, i_next;
    logic [NIDX-1:0]  cur_n_reg, cur_n_next, v_reg, v_next;
    logic [CNT_W-1:0] cur_i_reg, cur_i_next, cur_d_reg, cur_d_next;
    logic [CNT_W-1:0] sp_reg, sp_next, scan_reg, scan_next;
    logic [NODES-1:0] visited_reg, visited_next, dvalid_reg, dvalid_next;
    logic             dv_rd_reg, dv_rd_next;
    logic             pend_v_reg, pend_v_next, pend_ce_reg, pend_ce_next;
    logic [NIDX-1:0]  pend_n_reg, pend_n_next;
    logic             out_v_reg, out_v_next, out_ce_reg, out_ce_next;
    logic             out_last_reg, out_last_next;
    logic [NIDX-1:0]  out_n_reg, out_n_next;

    logic               deg_we;
    logic [NIDX-1:0]    deg_waddr, deg_raddr;
    logic [CNT_W-1:0]   deg_wdata, deg_rdata, deg_val;
    logic               nbr_we;
    logic [2*NIDX-1:0]  nbr_waddr, nbr_raddr;
    logic [NIDX-1:0]    nbr_wdata, nbr_rdata;
    logic               stk_we;
    logic [NIDX-1:0]    stk_waddr, stk_raddr;
    logic [SW-1:0]      stk_wdata, stk_rdata;

    logic [CNT_W-1:0] cnt;
    logic             in_acc, slot_free, emit_ok, a_ok, b_ok, v_ok, scan_ok;
    func_t            in_func;
    logic [ID_W-1:0]  in_a, in_b;
    logic             cfg_wr;
    logic [CNT_W-1:0] sp_m1, sp_m2;

    gdfs_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) deg_ram
    (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata)
    );

    gdfs_ram #(.WIDTH(NIDX), .DEPTH(1 << (2 * NIDX))) nbr_ram
    (
        .clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
        .raddr(nbr_raddr), .rdata(nbr_rdata)
    );

    gdfs_ram #(.WIDTH(SW), .DEPTH(NODES)) stk_ram
    (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    assign cnt       = (node_count_reg > NODES_C) ? NODES_C : node_count_reg;
    assign in_func   = func_t'(s_axis_tdata[1:0]);
    assign in_a      = s_axis_tdata[7:2];
    assign in_b      = s_axis_tdata[13:8];
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign a_ok      = CNT_W'(in_a) < cnt;
    assign b_ok      = CNT_W'(in_b) < cnt;
    assign v_ok      = (CNT_W'(nbr_rdata) < cnt) && !visited_reg[nbr_rdata];
    assign scan_ok   = scan_reg < cnt;
    assign slot_free = !out_v_reg || m_axis_tready;
    assign emit_ok   = !pend_v_reg || slot_free;
    assign deg_val   = dv_rd_reg ? deg_rdata : '0;
    assign sp_m1     = sp_reg - CNT_W'(1);
    assign sp_m2     = sp_reg - CNT_W'(2);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = 8'(out_n_reg);
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ce_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count_reg) : 32'd0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_func)
                        FUNC_ADD_EDGE: state_next = (a_ok && b_ok) ? ST_E_RD : ST_IDLE;
                        FUNC_WALK:     state_next = a_ok ? ST_W_START : ST_IDLE;
                        FUNC_WALK_ALL: state_next = ST_A_SCAN;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_E_RD:    state_next = ST_E_DEG;
            ST_E_DEG:   state_next = ST_E_SCAN;
            ST_E_SCAN:  state_next = (i_reg < d_reg) ? ST_E_CMP : ST_E_WR;
            ST_E_CMP:
            begin
                if (nbr_rdata == to_reg)
                begin
                    state_next = pass_reg ? ST_IDLE : ST_E_RD;
                end
                else
                begin
                    state_next = ST_E_SCAN;
                end
            end
            ST_E_WR:    state_next = pass_reg ? ST_IDLE : ST_E_RD;
            ST_W_START: state_next = emit_ok ? ST_W_DEG : ST_W_START;
            ST_W_DEG:   state_next = ST_W_STEP;
            ST_W_STEP:
            begin
                if (cur_i_reg < cur_d_reg)
                begin
                    state_next = ST_W_NBR;
                end
                else if (sp_reg == CNT_W'(1))
                begin
                    state_next = all_reg ? ST_A_SCAN : ST_FIN;
                end
                else
                begin
                    state_next = ST_W_POP;
                end
            end
            ST_W_NBR:   state_next = v_ok ? ST_W_PUSH : ST_W_STEP;
            ST_W_PUSH:  state_next = emit_ok ? ST_W_DEG : ST_W_PUSH;
            ST_W_POP:   state_next = ST_W_DEG;
            ST_A_SCAN:
            begin
                if (!scan_ok)
                begin
                    state_next = ST_FIN;
                end
                else if (!visited_reg[scan_reg[NIDX-1:0]])
                begin
                    state_next = ST_W_START;
                end
            end
            ST_FIN:     state_next = (!pend_v_reg || slot_free) ? ST_IDLE : ST_FIN;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        pass_next    = pass_reg;
        all_next     = all_reg;
        from_next    = from_reg;
        to_next      = to_reg;
        d_next       = d_reg;
        i_next       = i_reg;
        cur_n_next   = cur_n_reg;
        cur_i_next   = cur_i_reg;
        cur_d_next   = cur_d_reg;
        v_next       = v_reg;
        sp_next      = sp_reg;
        scan_next    = scan_reg;
        visited_next = visited_reg;
        dvalid_next  = dvalid_reg;
        pend_v_next  = pend_v_reg;
        pend_n_next  = pend_n_reg;
        pend_ce_next = pend_ce_reg;
        out_v_next   = out_v_reg && !m_axis_tready;
        out_n_next   = out_n_reg;
        out_ce_next  = out_ce_reg;
        out_last_next = out_last_reg;

        deg_we    = 1'b0;
        deg_waddr = from_reg;
        deg_wdata = d_reg + CNT_W'(1);
        nbr_we    = 1'b0;
        nbr_waddr = {from_reg, d_reg[NIDX-1:0]};
        nbr_wdata = to_reg;
        stk_we    = 1'b0;
        stk_waddr = sp_m1[NIDX-1:0];
        stk_wdata = {cur_n_reg, cur_i_reg};
        stk_raddr = sp_m2[NIDX-1:0];

        if (state_reg == ST_E_RD)
        begin
            deg_raddr = from_reg;
        end
        else if (state_reg == ST_W_POP)
        begin
            deg_raddr = stk_rdata[SW-1:CNT_W];
        end
        else
        begin
            deg_raddr = v_reg;
        end
        dv_rd_next = dvalid_reg[deg_raddr];

        if (state_reg == ST_E_SCAN)
        begin
            nbr_raddr = {from_reg, i_reg[NIDX-1:0]};
        end
        else
        begin
            nbr_raddr = {cur_n_reg, cur_i_reg[NIDX-1:0]};
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    from_next = in_a[NIDX-1:0];
                    to_next   = in_b[NIDX-1:0];
                    v_next    = in_a[NIDX-1:0];
                    pass_next = 1'b0;
                    scan_next = '0;
                    all_next  = (in_func == FUNC_WALK_ALL);
                    case (in_func)
                        FUNC_WALK,
                        FUNC_WALK_ALL: visited_next = '0;
                        FUNC_CLEAR:    dvalid_next = '0;
                        default:       visited_next = visited_reg;
                    endcase
                end
            end
            ST_E_DEG:
            begin
                d_next = deg_val;
                i_next = '0;
            end
            ST_E_CMP:
            begin
                if (nbr_rdata == to_reg)
                begin
                    from_next = to_reg;
                    to_next   = from_reg;
                    pass_next = 1'b1;
                end
                else
                begin
                    i_next = i_reg + CNT_W'(1);
                end
            end
            ST_E_WR:
            begin
                if (d_reg < NODES_C)
                begin
                    nbr_we = 1'b1;
                    deg_we = 1'b1;
                    dvalid_next[from_reg] = 1'b1;
                end
                from_next = to_reg;
                to_next   = from_reg;
                pass_next = 1'b1;
            end
            ST_W_START,
            ST_W_PUSH:
            begin
                if (emit_ok)
                begin
                    if (pend_v_reg)
                    begin
                        out_v_next    = 1'b1;
                        out_n_next    = pend_n_reg;
                        out_ce_next   = pend_ce_reg;
                        out_last_next = 1'b0;
                    end
                    pend_v_next  = 1'b1;
                    pend_n_next  = v_reg;
                    pend_ce_next = 1'b0;
                    visited_next[v_reg] = 1'b1;
                    cur_n_next = v_reg;
                    cur_i_next = '0;
                    if (state_reg == ST_W_PUSH)
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + CNT_W'(1);
                    end
                    else
                    begin
                        sp_next = CNT_W'(1);
                    end
                end
            end
            ST_W_DEG:
            begin
                cur_d_next = deg_val;
            end
            ST_W_STEP:
            begin
                if (cur_i_reg < cur_d_reg)
                begin
                    cur_i_next = cur_i_reg + CNT_W'(1);
                end
                else
                begin
                    sp_next = sp_m1;
                    if (sp_reg == CNT_W'(1))
                    begin
                        pend_ce_next = 1'b1;
                    end
                end
            end
            ST_W_NBR:
            begin
                v_next = nbr_rdata;
            end
            ST_W_POP:
            begin
                cur_n_next = stk_rdata[SW-1:CNT_W];
                cur_i_next = stk_rdata[CNT_W-1:0];
            end
            ST_A_SCAN:
            begin
                if (scan_ok)
                begin
                    if (visited_reg[scan_reg[NIDX-1:0]])
                    begin
                        scan_next = scan_reg + CNT_W'(1);
                    end
                    else
                    begin
                        v_next = scan_reg[NIDX-1:0];
                    end
                end
            end
            ST_FIN:
            begin
                if (pend_v_reg && slot_free)
                begin
                    out_v_next    = 1'b1;
                    out_n_next    = pend_n_reg;
                    out_ce_next   = pend_ce_reg;
                    out_last_next = 1'b1;
                    pend_v_next   = 1'b0;
                end
            end
            default:
            begin
                pass_next = pass_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            dvalid_reg     <= '0;
            visited_reg    <= '0;
            pend_v_reg     <= 1'b0;
            out_v_reg      <= 1'b0;
            sp_reg         <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            dvalid_reg  <= dvalid_next;
            visited_reg <= visited_next;
            pend_v_reg  <= pend_v_next;
            out_v_reg   <= out_v_next;
            sp_reg      <= sp_next;
            if (cfg_wr && pready && paddr[2] == REG_NODE_COUNT)
            begin
                node_count_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg     <= pass_next;
        all_reg      <= all_next;
        from_reg     <= from_next;
        to_reg       <= to_next;
        d_reg        <= d_next;
        i_reg        <= i_next;
        cur_n_reg    <= cur_n_next;
        cur_i_reg    <= cur_i_next;
        cur_d_reg    <= cur_d_next;
        v_reg        <= v_next;
        scan_reg     <= scan_next;
        dv_rd_reg    <= dv_rd_next;
        pend_n_reg   <= pend_n_next;
        pend_ce_reg  <= pend_ce_next;
        out_n_reg    <= out_n_next;
        out_ce_reg   <= out_ce_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- bench/graph_dfs_components_checker.sv -----
// Checker: predicts depth-first walk output from accepted requests and compares results.
`timescale 1ns / 1ps
module graph_dfs_components_checker
    import gdfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          pending
);

    typedef struct packed
    {
        logic [5:0] node;
        logic       comp_end;
        logic       walk_end;
    } visit_t;

    logic [5:0] adj [64][64];
    int         deg [64];
    bit         seen [64];
    logic [6:0] active_nodes;
    visit_t     visit_q [$];

    assign pending = visit_q.size();

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void add_visit(input visit_t r);
        visit_q.insert(visit_q.size(), r);
    endfunction

    function automatic void link(input int from, input int to);
        for (int i = 0; i < deg[from]; i++)
            if (adj[from][i] == to)
                return;
        if (deg[from] < 64)
        begin
            adj[from][deg[from]] = 6'(to);
            deg[from]++;
        end
    endfunction

    function automatic void dfs_from(input int start, input int lim);
        int stk_node [64];
        int stk_idx [64];
        int sp;
        int n;
        int v;
        visit_t r;
        seen[start] = 1;
        r = '{node: 6'(start), comp_end: 1'b0, walk_end: 1'b0};
        add_visit(r);
        sp = 1;
        stk_node[0] = start;
        stk_idx[0] = 0;
        while (sp > 0)
        begin
            n = stk_node[sp-1];
            if (stk_idx[sp-1] < deg[n])
            begin
                v = adj[n][stk_idx[sp-1]];
                stk_idx[sp-1]++;
                if (v < lim && !seen[v])
                begin
                    seen[v] = 1;
                    r = '{node: 6'(v), comp_end: 1'b0, walk_end: 1'b0};
                    add_visit(r);
                    stk_node[sp] = v;
                    stk_idx[sp] = 0;
                    sp++;
                end
            end
            else
                sp--;
        end
        visit_q[$].comp_end = 1;
    endfunction

    function automatic void predict(input func_t f, input int a, input int b);
        int lim;
        int base;
        lim = (active_nodes > 64) ? 64 : active_nodes;
        base = visit_q.size();
        case (f)
            FUNC_ADD_EDGE:
                if (a < lim && b < lim)
                begin
                    link(a, b);
                    link(b, a);
                end
            FUNC_WALK:
                if (a < lim)
                begin
                    foreach (seen[i]) seen[i] = 0;
                    dfs_from(a, lim);
                end
            FUNC_WALK_ALL:
            begin
                foreach (seen[i]) seen[i] = 0;
                for (int i = 0; i < lim; i++)
                    if (!seen[i])
                        dfs_from(i, lim);
            end
            FUNC_CLEAR:
                foreach (deg[i]) deg[i] = 0;
        endcase
        if (visit_q.size() > base)
            visit_q[$].walk_end = 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (deg[i]) deg[i] = 0;
            foreach (seen[i]) seen[i] = 0;
            active_nodes = NODE_COUNT_RST;
            visit_q.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_W'(0))
                active_nodes = pwdata[6:0];
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (visit_q.size() == 0)
                    report("unexpected result node", m_axis_tdata[5:0], -1);
                else
                begin
                    visit_t e;
                    e = visit_q.pop_front();
                    if (m_axis_tdata[5:0] !== e.node)
                        report("visited_node", m_axis_tdata[5:0], e.node);
                    if (m_axis_tdata[7:6] !== 2'b00)
                        report("tdata pad", m_axis_tdata[7:6], 0);
                    if (m_axis_tuser !== e.comp_end)
                        report("component_end", m_axis_tuser, e.comp_end);
                    if (m_axis_tlast !== e.walk_end)
                        report("last", m_axis_tlast, e.walk_end);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict(func_t'(s_axis_tdata[1:0]), s_axis_tdata[7:2], s_axis_tdata[13:8]);
        end
    end

endmodule

// ----- bench/graph_dfs_components_unit_test.sv -----
// Testbench top: drives requests and register writes, applies backpressure, gives the verdict.
`timescale 1ns / 1ps
module graph_dfs_components_unit_test;
    import gdfs_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              s_axis_tvalid = 0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 0;
    logic [7:0]        m_axis_tdata;
    logic              m_axis_tlast;
    logic              m_axis_tuser;
    logic              psel = 0;
    logic              penable = 0;
    logic              pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    int                errors;
    int                pending;
    int                idle_cycles = 0;
    int                stall_mode = 0;
    int                cyc = 0;
    int                lim = 64;

    always #6 clk = ~clk;

    graph_dfs_components_unit DUT (.*);

    graph_dfs_components_checker u_checker (.*);

    always @(posedge clk)
    begin
        cyc++;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("[graph_dfs_components_unit] ERROR");
            $finish;
        end
    end

    // receiver: alternates between free-flowing, random and bursty stalls
    always @(posedge clk)
    begin
        if (cyc % 500 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ((cyc / 7) % 3 != 0);
        endcase
    end

    task automatic write_count(input int value);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= '0; pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        lim = (value > 64) ? 64 : value;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send(input func_t f, input int a, input int b);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, 6'(b), 6'(a), f};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if ($urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic int pick_node();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 63);
        return (lim == 0) ? 0 : $urandom_range(0, lim - 1);
    endfunction

    task automatic random_phase(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send(FUNC_ADD_EDGE, pick_node(), pick_node());
            else if (r < 82)
                send(FUNC_WALK, pick_node(), $urandom_range(0, 63));
            else if (r < 94)
                send(FUNC_WALK_ALL, $urandom_range(0, 63), $urandom_range(0, 63));
            else
                send(FUNC_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
        end
        s_axis_tvalid <= 0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: self-loop, duplicate, extremes, out of range, clear
        send(FUNC_ADD_EDGE, 0, 63);
        send(FUNC_ADD_EDGE, 63, 0);
        send(FUNC_ADD_EDGE, 5, 5);
        send(FUNC_ADD_EDGE, 0, 5);
        send(FUNC_ADD_EDGE, 42, 21);
        send(FUNC_WALK, 0, 0);
        send(FUNC_WALK, 63, 63);
        send(FUNC_WALK, 42, 0);
        send(FUNC_WALK_ALL, 0, 0);
        send(FUNC_CLEAR, 0, 0);
        send(FUNC_WALK, 5, 0);
        s_axis_tvalid <= 0;
        drain();
        write_count(4);
        send(FUNC_ADD_EDGE, 1, 2);
        send(FUNC_ADD_EDGE, 1, 9);
        send(FUNC_WALK, 9, 0);
        send(FUNC_WALK_ALL, 0, 0);
        s_axis_tvalid <= 0;
        drain();
        write_count(0);
        send(FUNC_WALK_ALL, 0, 0);
        send(FUNC_WALK, 0, 0);
        s_axis_tvalid <= 0;
        drain();
        write_count(127);
        send(FUNC_ADD_EDGE, 3, 50);
        send(FUNC_WALK_ALL, 0, 0);
        s_axis_tvalid <= 0;
        drain();
        // shrink with wide lists stored, so high neighbors get skipped
        write_count(2);
        send(FUNC_WALK_ALL, 0, 0);
        s_axis_tvalid <= 0;
        drain();
        write_count(64);
        random_phase(70);
        drain();
        write_count($urandom_range(1, 12));
        random_phase(50);
        drain();
        write_count(1);
        random_phase(10);
        drain();
        write_count($urandom_range(20, 63));
        random_phase(70);
        drain();
        if (errors == 0)
            $display("[graph_dfs_components_unit] OK");
        else
            $display("[graph_dfs_components_unit] ERROR");
        $finish;
    end

endmodule
